>>> rtl/core/gbts_pkg.sv
// gbts_pkg: shared types and constants for the gap buffer text store
package gbts_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 13;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDATA,
    S_MOVE
  } seq_state_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   char_in;
    logic [OFFSET_W-1:0] offset;
    logic [POS_W-1:0]    position;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   char_out;
    logic [COUNT_W-1:0]  cursor_pos;
    logic [COUNT_W-1:0]  text_len;
  } res_t;

endpackage

>>> rtl/core/gbts_if.sv
// gbts_if: valid/ready channel interfaces for operations and results
interface gbts_in_if;
  import gbts_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic [CHAR_W-1:0]          char_in;
  logic signed [OFFSET_W-1:0] offset;
  logic [POS_W-1:0]           position;

  modport source (output valid, output op, output char_in, output offset,
                  output position, input ready);
  modport sink   (input valid, input op, input char_in, input offset,
                  input position, output ready);
endinterface

interface gbts_out_if;
  import gbts_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHAR_W-1:0]   char_out;
  logic [COUNT_W-1:0]  cursor_pos;
  logic [COUNT_W-1:0]  text_len;

  modport source (output valid, output status, output char_out, output cursor_pos,
                  output text_len, input ready);
  modport sink   (input valid, input status, input char_out, input cursor_pos,
                  input text_len, output ready);
endinterface

>>> rtl/core/gbts_mem.sv
// gbts_mem: character store, one write and one registered read per cycle
module gbts_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] cells_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cells_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= cells_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/gbts_seq.sv
// gbts_seq: operation sequencer, cursor and gap registers, move engine
module gbts_seq #(
  parameter int unsigned CAPACITY = 4096,
  parameter int unsigned AW       = 12,
  parameter int unsigned GW       = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gbts_pkg::item_t  item,
  input  logic             slot_free,
  output logic             res_load,
  output gbts_pkg::res_t   res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [7:0]       mem_rdata
);
  import gbts_pkg::*;

  localparam int unsigned TW = ((GW > OFFSET_W) ? GW : OFFSET_W) + 2;
  localparam int unsigned EW = ((GW > POS_W) ? GW : POS_W) + 1;

  seq_state_t state_r, state_nxt;
  logic [GW-1:0] gs_r, gs_nxt;
  logic [GW-1:0] gl_r, gl_nxt;
  logic [GW-1:0] tgt_r, tgt_nxt;
  logic [GW-1:0] cnt_r, cnt_nxt;
  logic          dir_r, dir_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          wr_pend_r, wr_pend_nxt;

  logic                 accept;
  logic [GW-1:0]        tl;
  logic [GW-1:0]        tl_nxt;
  logic signed [TW-1:0] target;
  logic signed [TW-1:0] diff;
  logic                 mv_bad;
  logic                 mv_right;
  logic                 mv_run;
  logic [GW-1:0]        mv_cnt;
  logic                 rd_bad;
  logic [AW-1:0]        rd_addr;

  assign in_ready = (state_r == S_IDLE) && slot_free;
  assign accept   = in_valid && in_ready;
  assign tl       = GW'(CAPACITY) - gl_r;

  // move target and distance
  assign target   = $signed(TW'(gs_r)) + TW'($signed(item.offset));
  assign diff     = target - $signed(TW'(gs_r));
  assign mv_bad   = (target < 0) || (target > $signed(TW'(tl)));
  assign mv_right = diff > 0;
  assign mv_run   = !mv_bad && (gl_r != '0) && (diff != 0);
  assign mv_cnt   = GW'(mv_right ? diff : -diff);

  // logical position to cell address
  assign rd_bad  = EW'(item.position) >= EW'(tl);
  assign rd_addr = (EW'(item.position) < EW'(gs_r)) ? AW'(item.position)
                                                    : AW'(EW'(item.position) + EW'(gl_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_READ && !rd_bad) begin
            state_nxt = S_RDATA;
          end else if (item.op == OP_MOVE && mv_run) begin
            state_nxt = S_MOVE;
          end
        end
      end
      S_RDATA: begin
        state_nxt = S_IDLE;
      end
      S_MOVE: begin
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    gs_nxt       = gs_r;
    gl_nxt       = gl_r;
    tgt_nxt      = tgt_r;
    cnt_nxt      = cnt_r;
    dir_nxt      = dir_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    wr_addr_nxt  = wr_addr_r;
    wr_pend_nxt  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = wr_addr_r;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = src_r;
    res_load     = 1'b0;
    res.status   = ST_OK;
    res.char_out = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (item.op)
            OP_INSERT: begin
              res_load = 1'b1;
              if (gl_r == '0) begin
                res.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(gs_r);
                mem_wdata = item.char_in;
                gs_nxt    = gs_r + GW'(1);
                gl_nxt    = gl_r - GW'(1);
              end
            end
            OP_MOVE: begin
              if (mv_bad) begin
                res_load   = 1'b1;
                res.status = ST_RANGE;
              end else if (!mv_run) begin
                res_load = 1'b1;
                gs_nxt   = GW'(target);
              end else begin
                tgt_nxt = GW'(target);
                cnt_nxt = mv_cnt;
                dir_nxt = mv_right;
                if (mv_right) begin
                  src_nxt = AW'(gs_r + gl_r);
                  dst_nxt = AW'(gs_r);
                end else begin
                  src_nxt = AW'(gs_r - GW'(1));
                  dst_nxt = AW'(gs_r - GW'(1) + gl_r);
                end
              end
            end
            OP_DELETE: begin
              res_load = 1'b1;
              if (gs_r == '0) begin
                res.status = ST_RANGE;
              end else begin
                gs_nxt = gs_r - GW'(1);
                gl_nxt = gl_r + GW'(1);
              end
            end
            OP_REPLACE: begin
              res_load = 1'b1;
              if (gs_r == '0) begin
                res.status = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(gs_r - GW'(1));
                mem_wdata = item.char_in;
              end
            end
            OP_READ: begin
              if (rd_bad) begin
                res_load   = 1'b1;
                res.status = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = rd_addr;
              end
            end
            default: begin
              res_load   = 1'b1;
              res.status = ST_RANGE;
            end
          endcase
        end
      end
      S_RDATA: begin
        res_load     = 1'b1;
        res.char_out = mem_rdata;
      end
      S_MOVE: begin
        // write of the character read last cycle, overlapped with the next read
        mem_we = wr_pend_r;
        if (cnt_r != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = src_r;
          wr_addr_nxt = dst_r;
          wr_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r - GW'(1);
          if (dir_r) begin
            src_nxt = src_r + AW'(1);
            dst_nxt = dst_r + AW'(1);
          end else begin
            src_nxt = src_r - AW'(1);
            dst_nxt = dst_r - AW'(1);
          end
        end else begin
          gs_nxt   = tgt_r;
          res_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
    tl_nxt         = GW'(CAPACITY) - gl_nxt;
    res.cursor_pos = COUNT_W'(gs_nxt);
    res.text_len   = COUNT_W'(tl_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      gs_r      <= '0;
      gl_r      <= GW'(CAPACITY);
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      gs_r      <= gs_nxt;
      gl_r      <= gl_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r     <= tgt_nxt;
    cnt_r     <= cnt_nxt;
    dir_r     <= dir_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

  a_gap_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (GW+1)'(gs_r) + (GW+1)'(gl_r) <= (GW+1)'(CAPACITY))
    else $error("cursor plus gap exceeds capacity");

  a_move_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && res_load) |-> (cnt_r == '0 && wr_pend_r))
    else $error("move finished with characters still in flight");

  a_move_gap_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |=> $stable(gl_r))
    else $error("gap length changed during a move");

  a_no_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same cell");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> slot_free)
    else $error("result produced while output register is occupied");

endmodule

>>> rtl/core/gap_buffer_text_store.sv
// gap_buffer_text_store: fixed-capacity gap buffer text store, top level
//
// Holds up to CAPACITY bytes of text split around a gap at the cursor. Each
// transaction on in_chan is one operation (insert, move cursor, delete or
// replace before the cursor, read at a logical position) and produces exactly
// one transaction on out_chan carrying status, the read character, the new
// cursor and the text length. Insert, delete, replace, unused op codes and any
// operation that fails its range check complete without leaving the idle state,
// so such operations run back to back. A read passes through S_RDATA while the
// registered read of the character store returns the character. A move that carries
// characters steps through S_MOVE: the store does one read and one write per cycle,
// so one character crosses the gap each cycle with its write overlapped onto the next
// read. A move with an empty gap only updates the cursor, without entering S_MOVE. The store needs no
// clearing after reset: only cells that hold text are ever read. Cells left
// behind by a move or freed by a delete keep their old contents, as gap cells
// are never read back. Results wait in an output register one transaction
// deep; a new operation is taken only while that register is empty or being
// claimed in the same cycle, so an unclaimed result holds off the input.
module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = 4096
) (
  input logic       clk,
  input logic       rst_n,
  gbts_in_if.sink   in_chan,
  gbts_out_if.source out_chan
);
  import gbts_pkg::*;

  // cell address width and width of cursor / gap counts (they reach CAPACITY)
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned GW = $clog2(CAPACITY + 1);

  item_t         item;
  res_t          res;
  res_t          out_res_r;
  logic          out_valid_r;
  logic          slot_free;
  logic          res_load;
  logic          in_ready;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // incoming transaction payload
  assign item.op       = in_chan.op;
  assign item.char_in  = in_chan.char_in;
  assign item.offset   = in_chan.offset;
  assign item.position = in_chan.position;
  assign in_chan.ready = in_ready;

  // the output register is free if empty or being drained this cycle
  assign slot_free = !out_valid_r || out_chan.ready;

  gbts_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .GW       (GW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .item      (item),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  gbts_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register, one transaction deep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_res_r.status;
  assign out_chan.char_out   = out_res_r.char_out;
  assign out_chan.cursor_pos = out_res_r.cursor_pos;
  assign out_chan.text_len   = out_res_r.text_len;

endmodule

>>> test/gbts_checker.sv
`timescale 1ns / 100ps
// gbts_checker: watches both channels, predicts each result and compares it
module gbts_checker #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  gbts_in_if          in_mon,
  gbts_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import gbts_pkg::*;

  localparam logic [CHAR_W-1:0] EMPTY_CELL  = 8'hFF;
  localparam int unsigned       PRINT_LIMIT = 40;

  logic [CHAR_W-1:0] text_cells [CAPACITY];
  int unsigned       cursor;
  int unsigned       gap_len;
  res_t              expected_q[$];
  res_t              oldest;

  task automatic report(input string msg);
    if (fail_count < PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // one operation on the shadow text, returning the result it should produce
  function automatic res_t apply_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                    input int off, input int unsigned pos);
    res_t r;
    int   target;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (gap_len == 0) begin
          r.status = ST_FULL;
        end else begin
          text_cells[cursor] = ch;
          cursor++;
          gap_len--;
        end
      end
      OP_MOVE: begin
        target = int'(cursor) + off;
        if (target < 0 || target > int'(CAPACITY - gap_len)) begin
          r.status = ST_RANGE;
        end else if (gap_len == 0) begin
          cursor = target;
        end else begin
          while (int'(cursor) < target) begin
            text_cells[cursor]           = text_cells[cursor + gap_len];
            text_cells[cursor + gap_len] = EMPTY_CELL;
            cursor++;
          end
          while (int'(cursor) > target) begin
            cursor--;
            text_cells[cursor + gap_len] = text_cells[cursor];
            text_cells[cursor]           = EMPTY_CELL;
          end
        end
      end
      OP_DELETE: begin
        if (cursor == 0) begin
          r.status = ST_RANGE;
        end else begin
          cursor--;
          text_cells[cursor] = EMPTY_CELL;
          gap_len++;
        end
      end
      OP_REPLACE: begin
        if (cursor == 0) r.status = ST_RANGE;
        else text_cells[cursor - 1] = ch;
      end
      OP_READ: begin
        if (pos >= CAPACITY - gap_len) r.status = ST_RANGE;
        else r.char_out = text_cells[(pos < cursor) ? pos : pos + gap_len];
      end
      default: r.status = ST_RANGE;
    endcase
    r.cursor_pos = COUNT_W'(cursor);
    r.text_len   = COUNT_W'(CAPACITY - gap_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cursor     = 0;
      gap_len    = CAPACITY;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(apply_op(in_mon.op, in_mon.char_in, in_mon.offset,
                                      in_mon.position));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report("result transaction with no operation outstanding");
        end else begin
          oldest = expected_q.pop_front();
          if (out_mon.status !== oldest.status)
            report($sformatf("status mismatch, got %0d, expected %0d",
                             out_mon.status, oldest.status));
          if (out_mon.char_out !== oldest.char_out)
            report($sformatf("char_out mismatch, got 0x%02h, expected 0x%02h",
                             out_mon.char_out, oldest.char_out));
          if (out_mon.cursor_pos !== oldest.cursor_pos)
            report($sformatf("cursor_pos mismatch, got %0d, expected %0d",
                             out_mon.cursor_pos, oldest.cursor_pos));
          if (out_mon.text_len !== oldest.text_len)
            report($sformatf("text_len mismatch, got %0d, expected %0d",
                             out_mon.text_len, oldest.text_len));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus, handshake idling and verdict for the gap buffer text store
module tb_top;
  import gbts_pkg::*;

  localparam int unsigned TEXT_CAP       = 4096;
  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned BLOCK_ITEMS    = 50;
  localparam int unsigned SMALL_TEXT     = 200;
  localparam int unsigned FULL_RANDOM    = 40;
  // a move carrying the whole text, plus the longest stall on either side,
  // fits several times over within this limit
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int          OFFSET_MAX     = 2 ** (OFFSET_W - 1) - 1;
  localparam int          OFFSET_MIN     = -(2 ** (OFFSET_W - 1));

  // op codes the block does not define
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;

  // stimulus-side view of the text, only used to aim moves and reads
  int unsigned cur;
  int unsigned len;

  bit          in_idle   = 1'b0;
  bit          out_stall = 1'b0;
  bit          running   = 1'b0;
  int unsigned quiet_cycles = 0;

  gbts_in_if  in_chan ();
  gbts_out_if out_chan ();

  gap_buffer_text_store #(
    .CAPACITY(TEXT_CAP)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  gbts_checker #(
    .CAPACITY(TEXT_CAP)
  ) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one operation transaction; valid stays high into the next call unless a
  // gap is drawn, so back-to-back transactions never drop valid
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input int off, input logic [POS_W-1:0] pos);
    int unsigned gap;
    int          target;
    gap = in_idle ? idle_cycles() : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.op       <= op;
    in_chan.char_in  <= ch;
    in_chan.offset   <= OFFSET_W'(off);
    in_chan.position <= pos;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    // follow cursor and length so later moves and reads can be aimed in range
    case (op)
      OP_INSERT: begin
        if (len < TEXT_CAP) begin
          cur++;
          len++;
        end
      end
      OP_MOVE: begin
        target = int'(cur) + off;
        if (target >= 0 && target <= int'(len)) cur = target;
      end
      OP_DELETE: begin
        if (cur != 0) begin
          cur--;
          len--;
        end
      end
      default: ;
    endcase
  endtask

  // random operation; unused fields carry random values so every bit toggles
  task automatic random_item(input int unsigned len_cap);
    int unsigned      pick;
    int               target;
    int               off;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    pick = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom);
    pos  = POS_W'($urandom);
    off  = $signed(OFFSET_W'($urandom));
    if (pick < 35) begin
      // keep the text near the wanted size by deleting once it is reached
      if (len < len_cap) send_item(OP_INSERT, ch, off, pos);
      else send_item(OP_DELETE, ch, off, pos);
    end else if (pick < 55) begin
      case ($urandom_range(0, 4))
        0: ;  // raw offset, mostly beyond the text
        1: begin
          target = int'($urandom_range(0, len));
          off    = target - int'(cur);
        end
        default: begin
          // short hop near the cursor, clipped to the text
          target = int'(cur) + int'($urandom_range(0, 32)) - 16;
          if (target < 0) target = 0;
          if (target > int'(len)) target = int'(len);
          off = target - int'(cur);
        end
      endcase
      send_item(OP_MOVE, ch, off, pos);
    end else if (pick < 67) begin
      send_item(OP_DELETE, ch, off, pos);
    end else if (pick < 75) begin
      send_item(OP_REPLACE, ch, off, pos);
    end else if (pick < 95) begin
      if (len != 0 && $urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, len - 1));
      send_item(OP_READ, ch, off, pos);
    end else begin
      send_item(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), ch, off, pos);
    end
  endtask

  // result side: ready held low for random stretches while stalling is on
  initial begin
    int unsigned stall;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = out_stall ? idle_cycles() : 0;
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  // watchdog: counts cycles in which no transaction completes on either side
  always @(posedge clk) begin
    if (!running || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gap_buffer_text_store test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_chan.valid    = 1'b0;
    in_chan.op       = OP_INSERT;
    in_chan.char_in  = '0;
    in_chan.offset   = '0;
    in_chan.position = '0;
    rst_n            = 1'b0;
    cur              = 0;
    len              = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    running <= 1'b1;
    @(negedge clk);

    // directed: empty buffer and small text corner cases, no idling on either side
    send_item(OP_READ, 8'h00, 0, '0);            // read of empty text
    send_item(OP_DELETE, 8'h00, 0, '0);          // delete at cursor zero
    send_item(OP_REPLACE, 8'hFF, 0, '0);         // replace at cursor zero
    send_item(OP_MOVE, 8'h00, 1, '0);            // move past the end
    send_item(OP_MOVE, 8'h00, -1, '0);           // move below zero
    send_item(OP_MOVE, 8'h00, 0, '0);            // null move
    send_item(OP_UNUSED_FIRST, 8'hFF, OFFSET_MAX, '1);
    send_item(OP_UNUSED_LAST, 8'h00, OFFSET_MIN, '0);
    send_item(OP_INSERT, 8'h00, 0, '0);
    send_item(OP_INSERT, 8'hFF, 0, '0);
    send_item(OP_INSERT, 8'hA5, 0, '0);
    send_item(OP_INSERT, 8'h5A, 0, '0);
    send_item(OP_READ, 8'h00, 0, POS_W'(0));
    send_item(OP_READ, 8'h00, 0, POS_W'(3));
    send_item(OP_READ, 8'h00, 0, POS_W'(4));     // read at the text length
    send_item(OP_READ, 8'h00, 0, '1);            // read at the top position
    send_item(OP_MOVE, 8'h00, -4, '0);           // carry all text behind the gap
    send_item(OP_READ, 8'h00, 0, POS_W'(0));
    send_item(OP_READ, 8'h00, 0, POS_W'(3));
    send_item(OP_REPLACE, 8'h11, 0, '0);         // replace with cursor back at zero
    send_item(OP_MOVE, 8'h00, 2, '0);
    send_item(OP_REPLACE, 8'hFF, 0, '0);
    send_item(OP_INSERT, 8'h3C, 0, '0);
    send_item(OP_DELETE, 8'h00, 0, '0);
    send_item(OP_MOVE, 8'h00, OFFSET_MAX, '0);   // offset extremes, out of range
    send_item(OP_MOVE, 8'h00, OFFSET_MIN, '0);
    send_item(OP_MOVE, 8'h00, int'(TEXT_CAP), '0);
    send_item(OP_MOVE, 8'h00, -int'(TEXT_CAP), '0);
    send_item(OP_READ, 8'h00, 0, POS_W'(1));

    // random: short texts, idling switched per block, some blocks with none
    for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
      in_idle   = ($urandom_range(0, 2) != 0);
      out_stall = ($urandom_range(0, 2) != 0);
      repeat (BLOCK_ITEMS) random_item(SMALL_TEXT);
    end

    in_idle = 1'b1;
    repeat (FULL_RANDOM) random_item(TEXT_CAP);

    in_chan.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    running <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("gap_buffer_text_store test passed");
    end else begin
      $display("gap_buffer_text_store test failed");
    end
    $finish;
  end

endmodule
